@@ hw/rtl/qet_pkg.sv @@
// qet_pkg: shared types, codes and constants of the queued easing tween engine.
// Used by qet_mul, qet_div and the top level; depends on nothing.
package qet_pkg;

    // Field widths
    localparam int VAL_W     = 24;
    localparam int DUR_W     = 16;
    localparam int TICK_W    = 17;
    localparam int RATE_W    = 17;
    localparam int EASE_W    = 3;
    localparam int MODE_W    = 2;
    localparam int QUEUED_W  = 4;

    // Serial arithmetic unit widths
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 16;

    // Q1.16 constants
    localparam logic [RATE_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [RATE_W-1:0] HALF_Q16    = 17'd32768;
    localparam logic [RATE_W-1:0] BACK_PEAK   = 17'd73728;   // 9/8
    localparam logic [RATE_W-1:0] BACK_CENTER = 17'd49152;   // 3/4
    localparam logic [DIV_DW-1:0] DIV_THREE   = 16'd3;
    localparam logic [DIV_DW-1:0] DIV_SQ_QUAD = 16'd49152;   // 196608 / 4

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_PUSH = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef enum logic [EASE_W-1:0] {
        EASE_LINEAR     = 3'd0,
        EASE_SINE_INOUT = 3'd1,
        EASE_SINE_OUT   = 3'd2,
        EASE_SINE_IN    = 3'd3,
        EASE_QUAD_INOUT = 3'd4,
        EASE_LIN_QUAD   = 3'd5,
        EASE_QUAD_LIN   = 3'd6,
        EASE_BACK_OUT   = 3'd7
    } ease_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_RATIO,
        ST_DIVR,
        ST_CURVE,
        ST_SQ,
        ST_SQDIV,
        ST_CDIV,
        ST_SPOS,
        ST_SINT,
        ST_BLEND,
        ST_BMUL,
        ST_STOPLD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [DUR_W-1:0]        duration;
        logic [DUR_W-1:0]        delay;
        logic [EASE_W-1:0]       ease;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [MUL_PW-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;

    // Quarter-wave sine entry from a Q30 angle: seven Taylor terms, rounded to Q16.
    // Evaluated at elaboration only.
    function automatic logic [RATE_W-1:0] sine_from_angle(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        a2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
            begin
                sum = sum - $signed(term);
            end else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        rounded = ($unsigned(sum) + 64'd8192) >> 14;
        return (rounded > 64'd65536) ? ONE_Q16 : rounded[RATE_W-1:0];
    endfunction

endpackage

@@ hw/rtl/qet_cmd_if.sv @@
// qet_cmd_if: input channel of the tween engine (valid/ready plus item fields).
// Depends on nothing.
interface qet_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [23:0] current_value;
    logic signed [23:0] target_value;
    logic [15:0]        duration_ticks;
    logic [15:0]        delay_ticks;
    logic [2:0]         ease_kind;
    logic               jump_flag;
    logic               clear_all;

    modport source (
        output valid, mode, current_value, target_value, duration_ticks,
               delay_ticks, ease_kind, jump_flag, clear_all,
        input  ready
    );

    modport sink (
        input  valid, mode, current_value, target_value, duration_ticks,
               delay_ticks, ease_kind, jump_flag, clear_all,
        output ready
    );
endinterface

@@ hw/rtl/qet_res_if.sv @@
// qet_res_if: result channel of the tween engine (valid/ready plus result fields).
// Depends on nothing.
interface qet_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_value;
    logic [16:0]        elapsed;
    logic [3:0]         queued;
    logic               push_dropped;

    modport source (
        output valid, out_value, elapsed, queued, push_dropped,
        input  ready
    );

    modport sink (
        input  valid, out_value, elapsed, queued, push_dropped,
        output ready
    );
endinterface

@@ hw/rtl/qet_ram.sv @@
// qet_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module qet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/qet_mul.sv @@
// qet_mul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on qet_pkg.
module qet_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  qet_pkg::mul_req_t req,
    output qet_pkg::mul_rsp_t rsp
);
    localparam int CntW = $clog2(qet_pkg::MUL_BW);

    logic [qet_pkg::MUL_PW-1:0] mcand_reg, mcand_next;
    logic [qet_pkg::MUL_BW-1:0] mplier_reg, mplier_next;
    logic [qet_pkg::MUL_PW-1:0] acc_reg, acc_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            mcand_next  = qet_pkg::MUL_PW'(req.a);
            mplier_next = req.b;
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(qet_pkg::MUL_BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;
endmodule

@@ hw/rtl/qet_div.sv @@
// qet_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on qet_pkg.
module qet_div (
    input  logic              clk,
    input  logic              rst_n,
    input  qet_pkg::div_req_t req,
    output qet_pkg::div_rsp_t rsp
);
    localparam int CntW = $clog2(qet_pkg::DIV_NW);

    logic [qet_pkg::DIV_NW-1:0] quo_reg, quo_next;
    logic [qet_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [qet_pkg::DIV_DW-1:0] dvsr_reg, dvsr_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [qet_pkg::DIV_DW:0]   trial;
    logic                       fits;

    always_comb
    begin
        trial       = {rem_reg, quo_reg[qet_pkg::DIV_NW-1]};
        fits        = trial >= {1'b0, dvsr_reg};
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg)
        begin
            rem_next = fits ? qet_pkg::DIV_DW'(trial - {1'b0, dvsr_reg})
                            : trial[qet_pkg::DIV_DW-1:0];
            quo_next = {quo_reg[qet_pkg::DIV_NW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(qet_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

@@ hw/rtl/queued_easing_tween_engine.sv @@
// queued_easing_tween_engine: top level with the queue RAM, sequencer and serial units.
// Depends on qet_pkg, qet_cmd_if, qet_res_if, qet_ram, qet_mul and qet_div.
//
// The engine takes one transaction at a time on cmd and returns exactly one result
// transaction on res for it. Push, stop and a tick with an empty queue do no
// arithmetic; a stop that jumps to a queued target first reads that entry. A tick
// runs its arithmetic on one shared bit-serial multiplier and one bit-serial
// divider: a linear tick is the shortest, a sine curve takes longer, and the
// quadratic curves that square and then divide take the longest. The result sits
// in an output register, so the next transaction is taken while it waits on res.
// Values are Q16.8, progress and curve rates Q1.16; the sine curves interpolate a
// quarter-wave table of SINE_TABLE_ENTRIES+1 constant entries.
module queued_easing_tween_engine #(
    parameter int QUEUE_DEPTH        = 8,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    qet_cmd_if.sink   cmd,
    qet_res_if.source res
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int TW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int EW = $bits(qet_pkg::entry_t);

    // Quarter-wave sine table, built at elaboration
    logic [qet_pkg::RATE_W-1:0] sine_tab [SINE_TABLE_ENTRIES + 1];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_sine
        localparam logic [63:0] Angle = qet_pkg::HALF_PI_Q30 * 64'(k) / SINE_TABLE_ENTRIES;
        assign sine_tab[k] = qet_pkg::sine_from_angle(Angle);
    end

    // Sequencer and architectural state
    qet_pkg::state_t state_reg, state_next;

    logic [qet_pkg::TICK_W-1:0]       tc_reg, tc_next;
    logic signed [qet_pkg::VAL_W-1:0] start_reg, start_next;
    logic [qet_pkg::DUR_W-1:0]        adur_reg, adur_next;
    logic [qet_pkg::DUR_W-1:0]        adly_reg, adly_next;
    logic [IW-1:0]                    head_reg, head_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;

    // Latched transaction fields
    logic [qet_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic signed [qet_pkg::VAL_W-1:0] cur_reg, cur_next;
    logic signed [qet_pkg::VAL_W-1:0] tgt_in_reg, tgt_in_next;
    logic [qet_pkg::DUR_W-1:0]        dur_in_reg, dur_in_next;
    logic [qet_pkg::DUR_W-1:0]        dly_in_reg, dly_in_next;
    logic [qet_pkg::EASE_W-1:0]       ease_in_reg, ease_in_next;
    logic                             jump_reg, jump_next;
    logic                             all_reg, all_next;

    // Working registers of a tick
    logic signed [qet_pkg::VAL_W-1:0] ent_val_reg, ent_val_next;
    logic [qet_pkg::EASE_W-1:0]       ease_reg, ease_next;
    logic [qet_pkg::RATE_W-1:0]       r_reg, r_next;
    logic [qet_pkg::RATE_W-1:0]       rate_reg, rate_next;
    logic [qet_pkg::RATE_W-1:0]       t0_reg, t0_next;
    logic                             neg_reg, neg_next;
    logic signed [qet_pkg::VAL_W-1:0] result_reg, result_next;
    logic                             drop_reg, drop_next;

    // Output register
    logic                             ovalid_reg, ovalid_next;
    logic signed [qet_pkg::VAL_W-1:0] oval_reg, oval_next;
    logic [qet_pkg::TICK_W-1:0]       oelap_reg, oelap_next;
    logic [qet_pkg::QUEUED_W-1:0]     oqueued_reg, oqueued_next;
    logic                             odrop_reg, odrop_next;

    // Queue RAM
    logic                             ram_we;
    logic [IW-1:0]                    ram_waddr, ram_raddr;
    qet_pkg::entry_t                  ram_wentry, ram_rentry;
    logic [EW-1:0]                    ram_rdata;

    qet_pkg::mul_req_t mul_req;
    qet_pkg::mul_rsp_t mul_rsp;
    qet_pkg::div_req_t div_req;
    qet_pkg::div_rsp_t div_rsp;

    // Queue index arithmetic, all sums below twice the depth (the back sum only while the queue is not empty)
    logic [SW-1:0] sum_tail, sum_back, sum_next_head;
    logic [IW-1:0] tail_idx, back_idx, head_inc;
    logic          queue_empty, queue_full;

    always_comb
    begin
        sum_tail      = SW'(head_reg) + SW'(cnt_reg);
        sum_back      = sum_tail - SW'(1);
        sum_next_head = SW'(head_reg) + SW'(1);
        tail_idx = IW'((sum_tail >= SW'(QUEUE_DEPTH)) ? sum_tail - SW'(QUEUE_DEPTH) : sum_tail);
        back_idx = IW'((sum_back >= SW'(QUEUE_DEPTH)) ? sum_back - SW'(QUEUE_DEPTH) : sum_back);
        head_inc = IW'((sum_next_head >= SW'(QUEUE_DEPTH))
                       ? sum_next_head - SW'(QUEUE_DEPTH) : sum_next_head);
        queue_empty = (cnt_reg == '0);
        queue_full  = (cnt_reg >= CW'(QUEUE_DEPTH));
    end

    assign ram_rentry = qet_pkg::entry_t'(ram_rdata);
    assign ram_waddr  = tail_idx;
    assign ram_raddr  = (mode_reg == qet_pkg::MODE_STOP && all_reg) ? back_idx : head_reg;
    assign ram_wentry = '{value: tgt_in_reg, duration: dur_in_reg, delay: dly_in_reg,
                          ease: ease_in_reg};

    qet_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qet_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    qet_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Rate from a sine sample for the three sine curves
    function automatic logic [qet_pkg::RATE_W-1:0] rate_of_sine(
        input logic [qet_pkg::EASE_W-1:0] kind,
        input logic                       lo,
        input logic [qet_pkg::RATE_W-1:0] s
    );
        logic [qet_pkg::RATE_W:0] t;
        case (kind)
            qet_pkg::EASE_SINE_INOUT:
                t = lo ? ({1'b0, qet_pkg::ONE_Q16} - {1'b0, s}) >> 1
                       : ({1'b0, qet_pkg::ONE_Q16} + {1'b0, s}) >> 1;
            qet_pkg::EASE_SINE_IN:
                t = {1'b0, qet_pkg::ONE_Q16} - {1'b0, s};
            default:
                t = {1'b0, s};
        endcase
        return t[qet_pkg::RATE_W-1:0];
    endfunction

    // Helpers for the datapath steps
    logic                             r_lo;
    logic [qet_pkg::RATE_W:0]         r_dbl;
    logic [qet_pkg::RATE_W-1:0]       sine_p;
    logic [qet_pkg::RATE_W-1:0]       r_comp;
    logic signed [qet_pkg::RATE_W:0]  back_d;
    logic [qet_pkg::RATE_W-1:0]       back_mag;
    logic [qet_pkg::RATE_W-1:0]       sq_shift;
    logic [TW-1:0]                    tab_idx, tab_idx1;
    logic signed [qet_pkg::RATE_W:0]  tab_diff;
    logic [qet_pkg::RATE_W-1:0]       tab_mag;
    logic signed [34:0]               interp_v;
    logic [qet_pkg::RATE_W-1:0]       interp_s;
    logic signed [qet_pkg::VAL_W:0]   val_diff;
    logic [qet_pkg::VAL_W:0]          val_mag;
    logic signed [qet_pkg::MUL_PW:0]  blend_prod;
    logic signed [qet_pkg::VAL_W+3:0] blend_sum;
    logic [qet_pkg::TICK_W-1:0]       tick_after;
    logic [qet_pkg::TICK_W-1:0]       tick_span;
    logic [qet_pkg::DIV_NW-1:0]       r_quot;
    logic                             can_out;

    always_comb
    begin
        r_lo     = r_reg < qet_pkg::HALF_Q16;
        r_dbl    = {r_reg, 1'b0};
        r_comp   = qet_pkg::ONE_Q16 - r_reg;
        back_d   = $signed({1'b0, r_reg}) - $signed({1'b0, qet_pkg::BACK_CENTER});
        back_mag = qet_pkg::RATE_W'(back_d[qet_pkg::RATE_W] ? -back_d : back_d);
        case (ease_reg)
            qet_pkg::EASE_SINE_INOUT:
                sine_p = qet_pkg::RATE_W'(r_lo ? {1'b0, qet_pkg::ONE_Q16} - r_dbl
                                               : r_dbl - {1'b0, qet_pkg::ONE_Q16});
            qet_pkg::EASE_SINE_IN:
                sine_p = r_comp;
            default:
                sine_p = r_reg;
        endcase

        sq_shift = mul_rsp.product[31:15];

        tab_idx  = mul_rsp.product[16 +: TW];
        tab_idx1 = tab_idx + TW'(1);
        tab_diff = $signed({1'b0, sine_tab[tab_idx1]}) - $signed({1'b0, sine_tab[tab_idx]});
        tab_mag  = qet_pkg::RATE_W'(tab_diff[qet_pkg::RATE_W] ? -tab_diff : tab_diff);

        interp_v = neg_reg ? $signed({2'b00, t0_reg, 16'd0}) - $signed({2'b00, mul_rsp.product[32:0]})
                           : $signed({2'b00, t0_reg, 16'd0}) + $signed({2'b00, mul_rsp.product[32:0]});
        interp_s = interp_v[34] ? '0 : interp_v[32:16];

        val_diff = $signed({ent_val_reg[qet_pkg::VAL_W-1], ent_val_reg})
                 - $signed({start_reg[qet_pkg::VAL_W-1], start_reg});
        val_mag  = val_diff[qet_pkg::VAL_W] ? $unsigned(-val_diff) : $unsigned(val_diff);

        blend_prod = neg_reg ? -$signed({1'b0, mul_rsp.product})
                             : $signed({1'b0, mul_rsp.product});
        blend_sum  = $signed({{4{start_reg[qet_pkg::VAL_W-1]}}, start_reg})
                   + $signed({blend_prod[qet_pkg::MUL_PW], blend_prod[qet_pkg::MUL_PW:16]});

        tick_span  = qet_pkg::TICK_W'(adur_reg) + qet_pkg::TICK_W'(adly_reg);
        tick_after = (tc_reg < tick_span) ? tc_reg + qet_pkg::TICK_W'(1) : '0;

        r_quot  = div_rsp.quotient;
        can_out = !ovalid_reg || res.ready;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        tc_next      = tc_reg;
        start_next   = start_reg;
        adur_next    = adur_reg;
        adly_next    = adly_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        cur_next     = cur_reg;
        tgt_in_next  = tgt_in_reg;
        dur_in_next  = dur_in_reg;
        dly_in_next  = dly_in_reg;
        ease_in_next = ease_in_reg;
        jump_next    = jump_reg;
        all_next     = all_reg;
        ent_val_next = ent_val_reg;
        ease_next    = ease_reg;
        r_next       = r_reg;
        rate_next    = rate_reg;
        t0_next      = t0_reg;
        neg_next     = neg_reg;
        result_next  = result_reg;
        drop_next    = drop_reg;
        ovalid_next  = ovalid_reg && !res.ready;
        oval_next    = oval_reg;
        oelap_next   = oelap_reg;
        oqueued_next = oqueued_reg;
        odrop_next   = odrop_reg;
        ram_we       = 1'b0;
        mul_req      = '0;
        div_req      = '0;
        cmd.ready    = 1'b0;

        case (state_reg)
            qet_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    mode_next    = cmd.mode;
                    cur_next     = cmd.current_value;
                    tgt_in_next  = cmd.target_value;
                    dur_in_next  = cmd.duration_ticks;
                    dly_in_next  = cmd.delay_ticks;
                    ease_in_next = cmd.ease_kind;
                    jump_next    = cmd.jump_flag;
                    all_next     = cmd.clear_all;
                    state_next   = qet_pkg::ST_DECODE;
                end
            end

            qet_pkg::ST_DECODE:
            begin
                result_next = cur_reg;
                drop_next   = 1'b0;
                state_next  = qet_pkg::ST_OUT;
                if (mode_reg == qet_pkg::MODE_TICK && !queue_empty)
                begin
                    state_next = qet_pkg::ST_LOAD;
                end else if (mode_reg == qet_pkg::MODE_PUSH)
                begin
                    ram_we    = !queue_full;
                    drop_next = queue_full;
                end else if (mode_reg == qet_pkg::MODE_STOP && jump_reg && !queue_empty)
                begin
                    state_next = qet_pkg::ST_STOPLD;
                end
            end

            qet_pkg::ST_STOPLD:
            begin
                result_next = ram_rentry.value;
                state_next  = qet_pkg::ST_OUT;
            end

            qet_pkg::ST_LOAD:
            begin
                ent_val_next = ram_rentry.value;
                ease_next    = ram_rentry.ease;
                if (tc_reg == '0)
                begin
                    start_next = cur_reg;
                    adur_next  = ram_rentry.duration;
                    adly_next  = ram_rentry.delay;
                end
                state_next = qet_pkg::ST_RATIO;
            end

            qet_pkg::ST_RATIO:
            begin
                if (tc_reg < qet_pkg::TICK_W'(adly_reg))
                begin
                    r_next     = '0;
                    state_next = qet_pkg::ST_CURVE;
                end else if (adur_reg == '0)
                begin
                    r_next     = qet_pkg::ONE_Q16;
                    state_next = qet_pkg::ST_CURVE;
                end else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = qet_pkg::DIV_NW'({tc_reg - qet_pkg::TICK_W'(adly_reg),
                                                         16'd0});
                    div_req.divisor  = adur_reg;
                    state_next       = qet_pkg::ST_DIVR;
                end
            end

            qet_pkg::ST_DIVR:
            begin
                if (div_rsp.done)
                begin
                    r_next = (r_quot > qet_pkg::DIV_NW'(qet_pkg::ONE_Q16))
                           ? qet_pkg::ONE_Q16 : r_quot[qet_pkg::RATE_W-1:0];
                    state_next = qet_pkg::ST_CURVE;
                end
            end

            qet_pkg::ST_CURVE:
            begin
                case (ease_reg)
                    qet_pkg::EASE_QUAD_INOUT:
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = qet_pkg::MUL_AW'(r_lo ? r_reg : r_comp);
                        mul_req.b     = r_lo ? r_reg : r_comp;
                        state_next    = qet_pkg::ST_SQ;
                    end
                    qet_pkg::EASE_BACK_OUT:
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = qet_pkg::MUL_AW'(back_mag);
                        mul_req.b     = back_mag;
                        state_next    = qet_pkg::ST_SQ;
                    end
                    qet_pkg::EASE_LIN_QUAD:
                    begin
                        if (r_lo)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = qet_pkg::DIV_NW'({r_reg, 2'b00});
                            div_req.divisor  = qet_pkg::DIV_THREE;
                            state_next       = qet_pkg::ST_CDIV;
                        end else
                        begin
                            mul_req.start = 1'b1;
                            mul_req.a     = qet_pkg::MUL_AW'(r_comp);
                            mul_req.b     = r_comp;
                            state_next    = qet_pkg::ST_SQ;
                        end
                    end
                    qet_pkg::EASE_QUAD_LIN:
                    begin
                        if (r_lo)
                        begin
                            mul_req.start = 1'b1;
                            mul_req.a     = qet_pkg::MUL_AW'(r_reg);
                            mul_req.b     = r_reg;
                            state_next    = qet_pkg::ST_SQ;
                        end else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = qet_pkg::DIV_NW'({r_reg, 2'b00})
                                             - qet_pkg::DIV_NW'(qet_pkg::ONE_Q16);
                            div_req.divisor  = qet_pkg::DIV_THREE;
                            state_next       = qet_pkg::ST_CDIV;
                        end
                    end
                    qet_pkg::EASE_SINE_INOUT, qet_pkg::EASE_SINE_OUT, qet_pkg::EASE_SINE_IN:
                    begin
                        if (sine_p == '0)
                        begin
                            rate_next  = rate_of_sine(ease_reg, r_lo, sine_tab[0]);
                            state_next = qet_pkg::ST_BLEND;
                        end else if (sine_p >= qet_pkg::ONE_Q16)
                        begin
                            rate_next  = rate_of_sine(ease_reg, r_lo,
                                                      sine_tab[SINE_TABLE_ENTRIES]);
                            state_next = qet_pkg::ST_BLEND;
                        end else
                        begin
                            mul_req.start = 1'b1;
                            mul_req.a     = qet_pkg::MUL_AW'(sine_p);
                            mul_req.b     = qet_pkg::MUL_BW'(SINE_TABLE_ENTRIES);
                            state_next    = qet_pkg::ST_SPOS;
                        end
                    end
                    default:
                    begin
                        rate_next  = r_reg;
                        state_next = qet_pkg::ST_BLEND;
                    end
                endcase
            end

            qet_pkg::ST_SQ:
            begin
                if (mul_rsp.done)
                begin
                    case (ease_reg)
                        qet_pkg::EASE_QUAD_INOUT:
                        begin
                            rate_next  = r_lo ? sq_shift : qet_pkg::ONE_Q16 - sq_shift;
                            state_next = qet_pkg::ST_BLEND;
                        end
                        qet_pkg::EASE_BACK_OUT:
                        begin
                            rate_next  = qet_pkg::BACK_PEAK - sq_shift;
                            state_next = qet_pkg::ST_BLEND;
                        end
                        default:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = mul_rsp.product[qet_pkg::DIV_NW-1:0];
                            div_req.divisor  = qet_pkg::DIV_SQ_QUAD;
                            state_next       = qet_pkg::ST_SQDIV;
                        end
                    endcase
                end
            end

            qet_pkg::ST_SQDIV:
            begin
                if (div_rsp.done)
                begin
                    rate_next = (ease_reg == qet_pkg::EASE_LIN_QUAD)
                              ? qet_pkg::ONE_Q16 - r_quot[qet_pkg::RATE_W-1:0]
                              : r_quot[qet_pkg::RATE_W-1:0];
                    state_next = qet_pkg::ST_BLEND;
                end
            end

            qet_pkg::ST_CDIV:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = r_quot[qet_pkg::RATE_W-1:0];
                    state_next = qet_pkg::ST_BLEND;
                end
            end

            qet_pkg::ST_SPOS:
            begin
                if (mul_rsp.done)
                begin
                    t0_next       = sine_tab[tab_idx];
                    neg_next      = tab_diff[qet_pkg::RATE_W];
                    mul_req.start = 1'b1;
                    mul_req.a     = qet_pkg::MUL_AW'(tab_mag);
                    mul_req.b     = qet_pkg::MUL_BW'(mul_rsp.product[15:0]);
                    state_next    = qet_pkg::ST_SINT;
                end
            end

            qet_pkg::ST_SINT:
            begin
                if (mul_rsp.done)
                begin
                    rate_next  = rate_of_sine(ease_reg, r_lo, interp_s);
                    state_next = qet_pkg::ST_BLEND;
                end
            end

            qet_pkg::ST_BLEND:
            begin
                neg_next      = val_diff[qet_pkg::VAL_W];
                mul_req.start = 1'b1;
                mul_req.a     = qet_pkg::MUL_AW'(val_mag);
                mul_req.b     = rate_reg;
                state_next    = qet_pkg::ST_BMUL;
            end

            qet_pkg::ST_BMUL:
            begin
                if (mul_rsp.done)
                begin
                    if (blend_sum > $signed(28'sd8388607))
                    begin
                        result_next = 24'sh7FFFFF;
                    end else if (blend_sum < $signed(-28'sd8388608))
                    begin
                        result_next = -24'sh800000;
                    end else
                    begin
                        result_next = blend_sum[qet_pkg::VAL_W-1:0];
                    end
                    state_next = qet_pkg::ST_OUT;
                end
            end

            qet_pkg::ST_OUT:
            begin
                if (can_out)
                begin
                    ovalid_next  = 1'b1;
                    oval_next    = result_reg;
                    odrop_next   = drop_reg;
                    oelap_next   = tc_reg;
                    oqueued_next = qet_pkg::QUEUED_W'(cnt_reg);
                    state_next   = qet_pkg::ST_IDLE;
                    if (mode_reg == qet_pkg::MODE_TICK && !queue_empty)
                    begin
                        tc_next    = tick_after;
                        oelap_next = tick_after;
                        if (tick_after == '0)
                        begin
                            head_next    = head_inc;
                            cnt_next     = cnt_reg - CW'(1);
                            oqueued_next = qet_pkg::QUEUED_W'(cnt_reg - CW'(1));
                        end
                    end else if (mode_reg == qet_pkg::MODE_PUSH && !queue_full)
                    begin
                        cnt_next     = cnt_reg + CW'(1);
                        oqueued_next = qet_pkg::QUEUED_W'(cnt_reg + CW'(1));
                    end else if (mode_reg == qet_pkg::MODE_STOP)
                    begin
                        tc_next    = '0;
                        oelap_next = '0;
                        if (all_reg)
                        begin
                            head_next    = tail_idx;
                            cnt_next     = '0;
                            oqueued_next = '0;
                        end else if (!queue_empty)
                        begin
                            head_next    = head_inc;
                            cnt_next     = cnt_reg - CW'(1);
                            oqueued_next = qet_pkg::QUEUED_W'(cnt_reg - CW'(1));
                        end
                    end
                end
            end

            default:
            begin
                state_next = qet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= qet_pkg::ST_IDLE;
            tc_reg     <= '0;
            start_reg  <= '0;
            adur_reg   <= '0;
            adly_reg   <= '0;
            head_reg   <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else
        begin
            state_reg  <= state_next;
            tc_reg     <= tc_next;
            start_reg  <= start_next;
            adur_reg   <= adur_next;
            adly_reg   <= adly_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        cur_reg     <= cur_next;
        tgt_in_reg  <= tgt_in_next;
        dur_in_reg  <= dur_in_next;
        dly_in_reg  <= dly_in_next;
        ease_in_reg <= ease_in_next;
        jump_reg    <= jump_next;
        all_reg     <= all_next;
        ent_val_reg <= ent_val_next;
        ease_reg    <= ease_next;
        r_reg       <= r_next;
        rate_reg    <= rate_next;
        t0_reg      <= t0_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
        drop_reg    <= drop_next;
        oval_reg    <= oval_next;
        oelap_reg   <= oelap_next;
        oqueued_reg <= oqueued_next;
        odrop_reg   <= odrop_next;
    end

    assign res.valid        = ovalid_reg;
    assign res.out_value    = oval_reg;
    assign res.elapsed      = oelap_reg;
    assign res.queued       = oqueued_reg;
    assign res.push_dropped = odrop_reg;
endmodule
